// File: src/mbps_pkg.sv
// Shared constants, types and lane selection for the masked byte pattern search.
package mbps_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int OFFSET_BITS = 32;
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int LEN_W       = 5;
    localparam int OFF_OUT_W   = 32;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int PAT_BITS    = 8 * MAX_PATTERN;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW    = 2'd0,
        CFG_PATTERN_HIGH   = 2'd1,
        CFG_WILDCARD_MASK  = 2'd2,
        CFG_PATTERN_LENGTH = 2'd3
    } cfg_index_t;

    // Compare setup for one window position.
    typedef struct packed {
        logic       active;
        logic       care;
        logic [7:0] pat;
    } lane_t;

    // back: distance from the newest byte; pattern byte len-1-back lines up with it.
    function automatic lane_t lane_for(input logic [IDX_W-1:0]    back,
                                       input logic [LEN_W-1:0]    len,
                                       input logic [PAT_BITS-1:0] pat,
                                       input logic [MAX_PATTERN-1:0] wild);
        lane_t            l;
        logic [LEN_W-1:0] j;
        logic [IDX_W-1:0] idx;
        j        = len - LEN_W'(1) - LEN_W'(back);
        idx      = j[IDX_W-1:0];
        l.active = LEN_W'(back) < len;
        l.care   = !wild[idx];
        l.pat    = pat[8*idx +: 8];
        return l;
    endfunction

endpackage

// File: src/mbps_cell.sv
// One window cell: holds a past byte, passes it on, compares it to its pattern byte.
module mbps_cell
    import mbps_pkg::*;
(
    input  logic       aclk,
    input  logic       shift_en,
    input  logic [7:0] byte_in,
    input  lane_t      lane,
    output logic [7:0] byte_out,
    output logic       hit
);

    logic [7:0] byte_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;
    assign hit      = !lane.active || !lane.care || (byte_reg == lane.pat);

endmodule

// File: src/masked_byte_pattern_search_top.sv
// Top level: masked byte pattern search over a byte stream with a sliding window of cells.
//
//  Port group   Dir  Transfer      Payload
//  s_*          in   byte          tdata = data_byte, tlast = last_byte
//  m_*          out  result        tuser = found, tdata = match_offset
//  cfg_*        in   reg write     cfg_index selects register, cfg_wdata value
//
//  One byte per cycle; the match decision for a byte is made in its accept cycle
//  from the cell row and the counter, and the result lands in the output register.
//  The output register lets a new byte in while the last result is being taken.
//  aresetn is synchronous, active low; no clearing pass.
//  s_tready drops only while a result is held and m_tready is low.
module masked_byte_pattern_search_top
    import mbps_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,    // [7:0] data_byte
    input  logic                 s_tlast,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OFF_OUT_W-1:0] m_tdata,    // [31:0] match_offset
    output logic                 m_tuser,    // [0] found

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    logic [63:0]            pattern_low_reg;
    logic [63:0]            pattern_high_reg;
    logic [15:0]            wildcard_mask_reg;
    logic [LEN_W-1:0]       pattern_length_reg;

    logic [OFFSET_BITS-1:0] bytes_seen_reg, bytes_seen_next;
    logic                   match_reported_reg, match_reported_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic                   m_found_reg, m_found_next;
    logic [OFF_OUT_W-1:0]   m_offset_reg, m_offset_next;

    logic                   s_fire;
    logic [127:0]           pat_all;
    logic [7:0]             link [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] hits;
    lane_t                  head_lane;
    logic                   len_ok;
    logic [LEN_W-1:0]       len_m1;
    logic                   window_match;
    logic                   count_max;
    logic [OFFSET_BITS-1:0] start_off;

    assign s_fire   = s_tvalid && s_tready;
    assign s_tready = !m_tvalid_reg || m_tready;
    assign pat_all  = {pattern_high_reg, pattern_low_reg};

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            wildcard_mask_reg  <= '0;
            pattern_length_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PATTERN_LOW:    pattern_low_reg    <= cfg_wdata[63:0];
                CFG_PATTERN_HIGH:   pattern_high_reg   <= cfg_wdata[63:0];
                CFG_WILDCARD_MASK:  wildcard_mask_reg  <= cfg_wdata[15:0];
                CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Window: newest byte compared at the head, past bytes in the cell row
    assign link[0]   = s_tdata;
    assign head_lane = lane_for(IDX_W'(0), pattern_length_reg, pat_all[PAT_BITS-1:0],
                                wildcard_mask_reg[MAX_PATTERN-1:0]);
    assign hits[0]   = !head_lane.active || !head_lane.care || (s_tdata == head_lane.pat);

    for (genvar k = 0; k < MAX_PATTERN - 1; k++) begin : g_cell
        mbps_cell u_cell (
            .aclk     (aclk),
            .shift_en (s_fire),
            .byte_in  (link[k]),
            .lane     (lane_for(IDX_W'(k + 1), pattern_length_reg, pat_all[PAT_BITS-1:0],
                                wildcard_mask_reg[MAX_PATTERN-1:0])),
            .byte_out (link[k+1]),
            .hit      (hits[k+1])
        );
    end

    assign len_ok       = (pattern_length_reg != '0) &&
                          (pattern_length_reg <= LEN_W'(MAX_PATTERN)) &&
                          !wildcard_mask_reg[0];
    assign len_m1       = pattern_length_reg - LEN_W'(1);
    assign window_match = len_ok && (bytes_seen_reg >= OFFSET_BITS'(len_m1)) && (&hits);
    assign count_max    = (bytes_seen_reg == '1);
    assign start_off    = count_max ? '1 : bytes_seen_reg - OFFSET_BITS'(len_m1);

    always_comb begin
        bytes_seen_next     = bytes_seen_reg;
        match_reported_next = match_reported_reg;
        m_tvalid_next       = m_tvalid_reg && !m_tready;
        m_found_next        = m_found_reg;
        m_offset_next       = m_offset_reg;
        if (s_fire) begin
            priority if (!match_reported_reg && window_match) begin
                m_tvalid_next       = 1'b1;
                m_found_next        = 1'b1;
                m_offset_next       = OFF_OUT_W'(start_off);
                match_reported_next = 1'b1;
            end else if (s_tlast && !match_reported_reg) begin
                m_tvalid_next = 1'b1;
                m_found_next  = 1'b0;
                m_offset_next = '0;
            end else begin
            end
            if (s_tlast) begin
                bytes_seen_next     = '0;
                match_reported_next = 1'b0;
            end else if (!count_max) begin
                bytes_seen_next = bytes_seen_reg + OFFSET_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_seen_reg     <= '0;
            match_reported_reg <= 1'b0;
            m_tvalid_reg       <= 1'b0;
        end else begin
            bytes_seen_reg     <= bytes_seen_next;
            match_reported_reg <= match_reported_next;
            m_tvalid_reg       <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_found_reg  <= m_found_next;
        m_offset_reg <= m_offset_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = m_offset_reg;

    a_region_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_tlast |=> (bytes_seen_reg == '0) && !match_reported_reg)
        else $error("region state not cleared after last byte");

    a_one_match: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && match_reported_reg && !s_tlast |=> match_reported_reg && !m_tvalid_next)
        else $error("second match reported in one region");

    a_count_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && !s_tlast && count_max |=> bytes_seen_reg == '1)
        else $error("byte counter wrapped");

    a_notfound_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("not-found result carries an offset");

endmodule
